@@ rtl/core/pli_pkg.sv @@
// Package for the piecewise linear interpolator: sizes, codes and word types.
// Used by pli_table, pli_muldiv and piecewise_linear_interpolator; no dependencies.
package pli_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned ValW       = 16;
  localparam int unsigned CntW       = 7;

  // Opcodes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Region codes of a result word.
  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  // Reset value of the entry count register.
  localparam logic [CntW-1:0] CountReset = CntW'(2);

  typedef struct packed {
    logic                   opcode;
    logic [IdxW-1:0]        entry_index;
    logic signed [ValW-1:0] entry_x;
    logic signed [ValW-1:0] entry_y;
    logic signed [ValW-1:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_y;
    logic [1:0]             region;
  } out_t;

  // One breakpoint row of the table.
  typedef struct packed {
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
  } entry_t;

  // Write command into the table.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } tbl_wr_t;

  // Command to the multiply-divide unit: floor(t * a / d), t <= d, d > 0.
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] t;
    logic [ValW-1:0] a;
    logic [ValW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] q;
  } md_rsp_t;

endpackage

@@ rtl/core/pli_table.sv @@
// Breakpoint table memory: one write port and one registered read port.
// Depends on pli_pkg.
module pli_table (
  input  logic                     clk_i,
  input  pli_pkg::tbl_wr_t         wr_i,
  input  logic [pli_pkg::IdxW-1:0] rd_addr_i,
  output pli_pkg::entry_t          rd_data_o
);
  import pli_pkg::*;

  entry_t mem [MaxEntries];
  entry_t rd_data_q;

  // Write one row when commanded.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read, every cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/pli_muldiv.sv @@
// Iterative multiply-divide unit: floor(t * a / d), one bit of a per cycle.
// Depends on pli_pkg.
module pli_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pli_pkg::md_req_t req_i,
  output pli_pkg::md_rsp_t rsp_o
);
  import pli_pkg::*;

  localparam int unsigned StepW = $clog2(ValW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [ValW-1:0]  t_q, t_d;
  logic [ValW-1:0]  a_q, a_d;
  logic [ValW-1:0]  d_q, d_d;
  logic [ValW-1:0]  r_q, r_d;
  logic [ValW-1:0]  q_q, q_d;

  logic [ValW+1:0]  r2;
  logic [ValW+1:0]  d1;
  logic [ValW+1:0]  d2;
  logic [1:0]       digit;
  logic [ValW+1:0]  r_next;

  // One step: shift the remainder, add t for a set bit of a, then take
  // out the divisor up to twice, since the sum stays below three divisors.
  always_comb begin
    r2 = {1'b0, r_q, 1'b0} + (a_q[ValW-1] ? {2'b00, t_q} : '0);
    d1 = {2'b00, d_q};
    d2 = {1'b0, d_q, 1'b0};
    if (r2 >= d2) begin
      r_next = r2 - d2;
      digit  = 2'd2;
    end else if (r2 >= d1) begin
      r_next = r2 - d1;
      digit  = 2'd1;
    end else begin
      r_next = r2;
      digit  = 2'd0;
    end
  end

  // Sequencing of the sixteen steps.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    t_d    = t_q;
    a_d    = a_q;
    d_d    = d_q;
    r_d    = r_q;
    q_d    = q_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      t_d    = req_i.t;
      a_d    = req_i.a;
      d_d    = req_i.d;
      r_d    = '0;
      q_d    = '0;
    end else if (busy_q) begin
      r_d    = r_next[ValW-1:0];
      q_d    = ValW'({q_q, 1'b0} + {{(ValW-1){1'b0}}, digit});
      a_d    = {a_q[ValW-2:0], 1'b0};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(ValW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    a_q <= a_d;
    d_q <= d_d;
    r_q <= r_d;
    q_q <= q_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

  // The remainder stays below the divisor during the run.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(req_i.start) |-> r_q < d_q)
    else $error("remainder reached the divisor");

  // The done strobe follows the last step of a run.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished run");

  // A new command is only given to an idle unit.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("start while the unit runs");

endmodule

@@ rtl/core/piecewise_linear_interpolator.sv @@
// Top level of the piecewise linear interpolator: sequencer over the table walk.
// Depends on pli_pkg, pli_table and pli_muldiv.
//
//   channel   ports                        direction  handshake
//   config    cfg_we_i, cfg_wdata_i        in         taken when cfg_we_i is high
//   command   start, busy, item_i          in         taken when start && !busy
//   result    done_o, result_o             out        one-cycle strobe on done_o
//
// A write word goes straight into the table; busy stays low. A query word reads
// the first and last rows (enough for a clamped answer), then walks the segments
// at one row a cycle, and an inner segment runs the bit-serial multiply-divide
// unit. The single table read port and the bit-serial divider bound the speed
// of a query. done_o comes in the cycle after the last step; the receiver cannot
// stall it. Reset sets the entry count to 2 and idles the sequencer; the table
// contents are kept as written.
module piecewise_linear_interpolator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pli_pkg::CntW-1:0] cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  pli_pkg::in_t             item_i,
  output logic                     done_o,
  output pli_pkg::out_t            result_o
);
  import pli_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  localparam logic signed [ValW+1:0] SatHi = (ValW+2)'((1 << (ValW - 1)) - 1);
  localparam logic signed [ValW+1:0] SatLo = -SatHi - (ValW+2)'(1);

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        count_q;
  logic [IdxW-1:0]        last_idx_q, last_idx_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic signed [ValW-1:0] qx_q, qx_d;
  logic signed [ValW-1:0] prev_x_q, prev_x_d;
  logic signed [ValW-1:0] prev_y_q, prev_y_d;
  logic signed [ValW-1:0] last_y_q, last_y_d;
  logic                   neg_q, neg_d;
  logic                   done_q, done_d;
  out_t                   res_q, res_d;

  logic                   accept;
  logic [CntW-1:0]        count_eff;
  tbl_wr_t                tbl_wr;
  logic [IdxW-1:0]        rd_addr;
  entry_t                 rd_data;
  logic                   md_start;
  md_req_t                md_req;
  md_rsp_t                md_rsp;

  logic [ValW:0]          span;
  logic [ValW:0]          offs;
  logic [ValW:0]          dy;
  logic [ValW:0]          dy_abs;
  logic signed [ValW+1:0] sum;

  // Saturate an 18-bit sum into the result range.
  function automatic logic signed [ValW-1:0] sat(input logic signed [ValW+1:0] v);
    logic signed [ValW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[ValW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[ValW-1:0];
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Count in use, held between 2 and the table depth.
  always_comb begin
    if (count_q < CntW'(2)) begin
      count_eff = CntW'(2);
    end else if (count_q > CntW'(MaxEntries)) begin
      count_eff = CntW'(MaxEntries);
    end else begin
      count_eff = count_q;
    end
  end

  // Table writes come straight from an accepted write word.
  assign tbl_wr.we   = accept && (item_i.opcode == OP_WRITE);
  assign tbl_wr.addr = item_i.entry_index;
  assign tbl_wr.data = '{x: item_i.entry_x, y: item_i.entry_y};

  // Row read in each state, so that its data is there in the next one.
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = '0;
      S_FIRST: rd_addr = last_idx_q;
      S_LAST:  rd_addr = IdxW'(1);
      S_WALK:  rd_addr = idx_q + IdxW'(1);
      default: rd_addr = '0;
    endcase
  end

  pli_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Segment terms between the previous row and the row just read.
  assign span   = {rd_data.x[ValW-1], rd_data.x} - {prev_x_q[ValW-1], prev_x_q};
  assign offs   = {qx_q[ValW-1], qx_q} - {prev_x_q[ValW-1], prev_x_q};
  assign dy     = {rd_data.y[ValW-1], rd_data.y} - {prev_y_q[ValW-1], prev_y_q};
  assign dy_abs = dy[ValW] ? (~dy + (ValW+1)'(1)) : dy;

  assign md_req.start = md_start;
  assign md_req.t     = offs[ValW-1:0];
  assign md_req.a     = dy_abs[ValW-1:0];
  assign md_req.d     = span[ValW-1:0];

  pli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Final value from the segment start and the scaled step.
  assign sum = neg_q
    ? {{2{prev_y_q[ValW-1]}}, prev_y_q} - $signed({2'b00, md_rsp.q})
    : {{2{prev_y_q[ValW-1]}}, prev_y_q} + $signed({2'b00, md_rsp.q});

  // Query sequencer.
  always_comb begin
    state_d    = state_q;
    last_idx_d = last_idx_q;
    idx_d      = idx_q;
    qx_d       = qx_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    last_y_d   = last_y_q;
    neg_d      = neg_q;
    done_d     = 1'b0;
    res_d      = res_q;
    md_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && item_i.opcode == OP_QUERY) begin
          qx_d       = item_i.query_x;
          last_idx_d = IdxW'(count_eff - CntW'(1));
          state_d    = S_FIRST;
        end
      end
      S_FIRST: begin
        prev_x_d = rd_data.x;
        prev_y_d = rd_data.y;
        if (qx_q <= rd_data.x) begin
          done_d  = 1'b1;
          res_d   = '{result_y: rd_data.y, region: REGION_BELOW};
          state_d = S_IDLE;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        last_y_d = rd_data.y;
        idx_d    = IdxW'(1);
        if (qx_q >= rd_data.x) begin
          done_d  = 1'b1;
          res_d   = '{result_y: rd_data.y, region: REGION_ABOVE};
          state_d = S_IDLE;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (qx_q >= prev_x_q && qx_q <= rd_data.x) begin
          if (span == '0) begin
            done_d  = 1'b1;
            res_d   = '{result_y: prev_y_q, region: REGION_INSIDE};
            state_d = S_IDLE;
          end else begin
            md_start = 1'b1;
            neg_d    = dy[ValW];
            state_d  = S_DIV;
          end
        end else begin
          prev_x_d = rd_data.x;
          prev_y_d = rd_data.y;
          if (idx_q == last_idx_q) begin
            // Table not increasing: no segment holds x.
            done_d  = 1'b1;
            res_d   = '{result_y: last_y_q, region: REGION_INSIDE};
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_DIV: begin
        if (md_rsp.done) begin
          done_d  = 1'b1;
          res_d   = '{result_y: sat(sum), region: REGION_INSIDE};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    idx_q      <= idx_d;
    qx_q       <= qx_d;
    prev_x_q   <= prev_x_d;
    prev_y_q   <= prev_y_d;
    last_y_q   <= last_y_d;
    neg_q      <= neg_d;
    res_q      <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A result word closes a query that kept the block busy.
  a_done_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result word without a running query");

  // Result words never come in two consecutive cycles.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // The walk stays inside the rows in use.
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> idx_q != '0 && idx_q <= last_idx_q)
    else $error("walk index outside the table in use");

  // The divider is only awaited after it was started.
  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && $past(state_q) != S_DIV |-> $past(md_start))
    else $error("divide state entered without a start");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_interpolator: table loads, queries, count changes.
// Depends on pli_pkg and the RTL; a class scoreboard predicts every answer word.

module tb;
  import pli_pkg::*;

  localparam int unsigned ItemTarget   = 1700;
  localparam int unsigned CalmTail     = 150;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned CycleLimit   = 1500000;
  localparam int unsigned ReportLimit  = 10;

  // Scoreboard: shadow table, count register and the answers still owed.
  class lut_scoreboard;
    logic signed [ValW-1:0] row_x [MaxEntries];
    logic signed [ValW-1:0] row_y [MaxEntries];
    logic [CntW-1:0]        entry_count;
    out_t                   expected_answers [$];
    int unsigned            mismatches;

    function new();
      entry_count = CountReset;
      mismatches  = 0;
    endfunction

    function void set_count(logic [CntW-1:0] value);
      entry_count = value;
    endfunction

    // Counts outside the legal range act as the nearest legal one.
    function int unsigned rows_in_use();
      if (entry_count < 2) return 2;
      if (entry_count > MaxEntries) return MaxEntries;
      return entry_count;
    endfunction

    // Interpolated answer for a query at qx against the shadow table.
    function out_t interpolate_at(logic signed [ValW-1:0] qx);
      int unsigned n;
      longint xq, x0, x1, y0, dy, span, run, mag, q, yv, hi, lo;
      logic [1:0] zone;
      bit found;
      out_t ans;
      n     = rows_in_use();
      xq    = qx;
      zone  = REGION_INSIDE;
      found = 1'b0;
      x0    = row_x[0];
      x1    = row_x[n-1];
      yv    = row_y[n-1];
      if (xq <= x0) begin
        yv   = row_y[0];
        zone = REGION_BELOW;
      end else if (xq >= x1) begin
        zone = REGION_ABOVE;
      end else begin
        // First segment whose end points enclose the query wins.
        for (int i = 0; i + 1 < n && !found; i++) begin
          x0 = row_x[i];
          x1 = row_x[i+1];
          if (xq >= x0 && xq <= x1) begin
            found = 1'b1;
            y0    = row_y[i];
            dy    = longint'(row_y[i+1]) - y0;
            span  = x1 - x0;
            yv    = y0;
            // A zero-span segment answers its first y.
            if (span != 0) begin
              run = xq - x0;
              mag = (dy < 0) ? -dy : dy;
              q   = (run * mag) / span;
              yv  = (dy < 0) ? y0 - q : y0 + q;
            end
          end
        end
      end
      hi = (longint'(1) << (ValW - 1)) - 1;
      lo = -hi - 1;
      if (yv > hi) yv = hi;
      if (yv < lo) yv = lo;
      ans.result_y = yv[ValW-1:0];
      ans.region   = zone;
      return ans;
    endfunction

    // Called for every accepted command word.
    function void note_word(in_t w);
      if (w.opcode == OP_WRITE) begin
        row_x[w.entry_index] = w.entry_x;
        row_y[w.entry_index] = w.entry_y;
      end else begin
        expected_answers.push_back(interpolate_at(w.query_x));
      end
    endfunction

    // Called for every answer word on the result port.
    function void check_result(out_t got);
      out_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected answer word: result_y=%0d region=%0d",
                   got.result_y, got.region);
        return;
      end
      want = expected_answers.pop_front();
      if (got.result_y !== want.result_y || got.region !== want.region) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("answer mismatch: expected result_y=%0d region=%0d, got result_y=%0d region=%0d",
                   want.result_y, want.region, got.result_y, got.region);
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            start       = 1'b0;
  logic            busy;
  in_t             item_i      = '0;
  logic            done_o;
  out_t            result_o;

  lut_scoreboard sb;
  int unsigned   words_sent = 0;
  int unsigned   cycles     = 0;
  bit            gaps_on    = 1'b0;

  piecewise_linear_interpolator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Answer words cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(result_o);
  end

  // Watchdog against a hung handshake or a missing answer.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic in_t random_word();
    logic [$bits(in_t)-1:0] bits;
    bits = $bits(in_t)'({$urandom, $urandom});
    return in_t'(bits);
  endfunction

  function automatic int random_value();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clamp_value(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Hold start high until the block takes the word, then log it.
  task automatic send_word(in_t w);
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_word(w);
    words_sent++;
  endtask

  // Random idle burst on the command side.
  task automatic maybe_pause();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start  <= 1'b0;
      item_i <= random_word();
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Let every answer arrive and the block go quiet.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CntW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CntW'($urandom);
    sb.set_count(value);
  endtask

  // Write word: the query field rides along with random content.
  task automatic write_row(int idx, int x, int y);
    in_t w;
    w             = random_word();
    w.opcode      = OP_WRITE;
    w.entry_index = IdxW'(idx);
    w.entry_x     = ValW'(x);
    w.entry_y     = ValW'(y);
    send_word(w);
    maybe_pause();
  endtask

  // Query word: the entry fields ride along with random content.
  task automatic query_at(int x);
    in_t w;
    w         = random_word();
    w.opcode  = OP_QUERY;
    w.query_x = ValW'(x);
    send_word(w);
    maybe_pause();
  endtask

  // Query positions that favor breakpoints, their neighbors and segment interiors.
  function automatic int pick_query_x(int n);
    int k, lo, hi;
    k  = $urandom_range(0, n - 2);
    lo = sb.row_x[k];
    hi = sb.row_x[k+1];
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2, 3:    return ($urandom_range(0, 1) != 0) ? lo : hi;
      4:       return clamp_value(lo + (($urandom_range(0, 1) != 0) ? 1 : -1));
      5, 6, 7: return (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
      8: begin
        if ($urandom_range(0, 1) != 0)
          return clamp_value(int'(sb.row_x[0]) - int'($urandom_range(0, 300)));
        return clamp_value(int'(sb.row_x[n-1]) + int'($urandom_range(0, 300)));
      end
      default: return random_value();
    endcase
  endfunction

  // Load rows 0..n-1 in random order; mostly increasing x, sometimes
  // repeated x, sometimes no order at all, sometimes the full x range.
  task automatic load_rows(int n);
    int xs [MaxEntries];
    int ys [MaxEntries];
    int order [MaxEntries];
    int shape, span, base, ybase, slope, tmp, j;
    shape = $urandom_range(0, 9);
    span  = 1 << $urandom_range(3, 16);
    base  = random_value();
    ybase = random_value();
    slope = $urandom_range(0, 1) != 0 ? int'($urandom_range(0, 600)) - 300 : 0;
    for (int i = 0; i < n; i++) begin
      if (shape == 9) xs[i] = -32768 + (i * 65535) / (n - 1);
      else if (shape == 8) xs[i] = random_value();
      else xs[i] = clamp_value(base + int'($urandom_range(0, span)));
      ys[i] = (slope != 0) ? clamp_value(ybase + i * slope) : random_value();
      order[i] = i;
    end
    if (shape < 8) begin
      for (int i = 1; i < n; i++) begin
        tmp = xs[i];
        j   = i - 1;
        while (j >= 0 && xs[j] > tmp) begin
          xs[j+1] = xs[j];
          j--;
        end
        xs[j+1] = tmp;
      end
      if (shape == 7) begin
        for (int i = 1; i < n; i++)
          if ($urandom_range(0, 2) == 0) xs[i] = xs[i-1];
      end
    end
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) write_row(order[i], xs[order[i]], ys[order[i]]);
    // Rows past the count in use are written too but never read.
    if (n < MaxEntries) begin
      repeat ($urandom_range(0, 2))
        write_row($urandom_range(n, MaxEntries - 1), random_value(), random_value());
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    logic [CntW-1:0] count_value;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two rows spanning the full range, then a steep rising
    // segment, queries at and beside both ends and inside.
    write_row(0, -32768, 32767);
    write_row(1, 32767, -32768);
    query_at(-32768);
    query_at(32767);
    query_at(0);
    query_at(-32767);
    query_at(32766);
    write_row(0, -256, -32768);
    write_row(1, 256, 32767);
    query_at(0);
    query_at(-255);
    query_at(255);
    query_at(1);
    query_at(-256);
    query_at(256);
    query_at(-257);
    write_row(MaxEntries - 1, 32767, -1);
    drain();

    // Random phases: a count setting, a fresh table, then a run of queries
    // with an occasional row rewrite. Counts start at the extremes.
    phase = 0;
    while (words_sent < ItemTarget) begin
      case (phase)
        0: count_value = CntW'(127);
        1: count_value = CntW'(0);
        2: count_value = CntW'(1);
        3: count_value = CntW'(MaxEntries);
        4: count_value = CntW'(MaxEntries + 1);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) count_value = CntW'($urandom_range(2, 8));
          else if (pick < 8) count_value = CntW'($urandom_range(9, MaxEntries - 1));
          else if (pick == 8) count_value = CntW'(MaxEntries);
          else count_value = CntW'($urandom_range(0, 127));
        end
      endcase
      write_count(count_value);
      n       = sb.rows_in_use();
      gaps_on = ($urandom_range(0, 3) != 0) && (words_sent + CalmTail < ItemTarget);
      load_rows(n);
      repeat ($urandom_range(10, 40)) begin
        if (words_sent + CalmTail >= ItemTarget) gaps_on = 1'b0;
        if ($urandom_range(0, 9) == 0)
          write_row($urandom_range(0, n - 1), random_value(), random_value());
        else
          query_at(pick_query_x(n));
      end
      drain();
      phase++;
    end

    if (sb.mismatches == 0 && sb.expected_answers.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
